// ----- rtl/core/lsrs_pkg.sv -----
// Package for the live slot rank/select block: sizes, codes, state types and payload structs.
package lsrs_pkg;

  // Position space and block geometry
  localparam int unsigned MaxPos   = 4096;
  localparam int unsigned BlkLen   = 64;
  localparam int unsigned BlkCount = 64;

  localparam int unsigned PosW  = 13;
  localparam int unsigned StepW = 12;
  localparam int unsigned OfsW  = $clog2(BlkLen);
  localparam int unsigned BlkW  = $clog2(BlkCount);
  localparam int unsigned CntW  = $clog2(BlkLen + 1);
  localparam int unsigned RowW  = CntW + BlkLen;

  localparam logic [PosW-1:0] MaxPosC = PosW'(MaxPos);

  // Opcodes
  localparam logic [2:0] OpClear  = 3'd0;
  localparam logic [2:0] OpDelete = 3'd1;
  localparam logic [2:0] OpNext   = 3'd2;
  localparam logic [2:0] OpPrev   = 3'd3;
  localparam logic [2:0] OpCount  = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEL_RD,
    ST_DEL_CHK,
    ST_WALK_RD,
    ST_WALK_SCAN,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    WK_NEXT,
    WK_PREV,
    WK_COUNT,
    WK_LAST,
    WK_FIRST
  } walk_e;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [PosW-1:0]  position_a;
    logic [PosW-1:0]  position_b;
    logic [StepW-1:0] step;
  } req_t;

  typedef struct packed {
    logic [PosW-1:0] value;
    logic            error;
    logic [PosW-1:0] first_live;
    logic [PosW-1:0] last_live;
  } rsp_t;

endpackage

// ----- rtl/core/live_slot_rank_select_top.sv -----
// Top level of the live slot rank/select block: control sequencer around one row RAM.
//
// Positions 1..4096 are kept as 64 RAM rows, one per block of 64 positions; each row holds
// the block's live count and its 64 dead bits. One request gives one response. After reset,
// and for every clear, a sweep writes all 64 rows, one a cycle, with no request taken.
// Next and previous walk the rows through the single read port: blocks are skipped whole
// by their count, and the start and end blocks are scanned one position at a time. Count
// between is the same walk. A delete reads and checks the row and writes it back, then
// runs one or two such walks when it removes the first or last live position. A zero step
// answers without a walk. The response sits in an output register, so a new request is
// taken while it waits.
module live_slot_rank_select_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [lsrs_pkg::PosW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  lsrs_pkg::req_t           in_req_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output lsrs_pkg::rsp_t           out_rsp_o
);

  localparam int unsigned PosW = lsrs_pkg::PosW;
  localparam int unsigned OfsW = lsrs_pkg::OfsW;
  localparam int unsigned BlkW = lsrs_pkg::BlkW;
  localparam int unsigned CntW = lsrs_pkg::CntW;
  localparam int unsigned RowW = lsrs_pkg::RowW;
  localparam int unsigned StepW = lsrs_pkg::StepW;
  localparam int unsigned BlkLen = lsrs_pkg::BlkLen;

  lsrs_pkg::state_e state_q, state_d;
  lsrs_pkg::walk_e  walk_q, walk_d;

  logic [PosW-1:0]  cfg_q, cfg_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [StepW-1:0] rem_q, rem_d;
  logic [PosW-1:0]  acc_q, acc_d;
  logic [PosW-1:0]  lim_q, lim_d;
  logic [PosW-1:0]  a_q, a_d;
  logic [BlkW-1:0]  clr_idx_q, clr_idx_d;
  logic [PosW-1:0]  clr_cnt_q, clr_cnt_d;
  logic             clr_op_q, clr_op_d;
  logic [PosW-1:0]  first_q, first_d;
  logic [PosW-1:0]  last_q, last_d;
  logic [PosW-1:0]  res_val_q, res_val_d;
  logic             res_err_q, res_err_d;
  logic             out_valid_q, out_valid_d;
  lsrs_pkg::rsp_t   out_rsp_q, out_rsp_d;

  // RAM port signals
  logic            ram_we, ram_re;
  logic [BlkW-1:0] ram_waddr, ram_raddr;
  logic [RowW-1:0] ram_wdata, ram_rdata;

  lsrs_ram #(
    .WIDTH (RowW),
    .DEPTH (lsrs_pkg::BlkCount)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Decode the row word and the walk position
  logic [CntW-1:0]   row_cnt;
  logic [BlkLen-1:0] row_dead;
  logic [PosW-1:0]   pos_m1, a_m1;
  logic              backward, walk_end, blk_edge, skip, pos_live, hit;
  logic [PosW-1:0]   pos_step;
  logic              step_new_blk;
  logic              accept, out_load;
  logic [PosW-1:0]   eff_cnt;

  assign row_cnt  = ram_rdata[RowW-1:BlkLen];
  assign row_dead = ram_rdata[BlkLen-1:0];
  assign pos_m1   = pos_q - PosW'(1);
  assign a_m1     = a_q - PosW'(1);
  assign pos_live = !row_dead[pos_m1[OfsW-1:0]];
  assign backward = (walk_q == lsrs_pkg::WK_PREV) || (walk_q == lsrs_pkg::WK_LAST);

  always_comb begin
    if (backward) begin
      walk_end = (pos_q == '0);
    end else if (walk_q == lsrs_pkg::WK_COUNT) begin
      walk_end = (pos_q > lim_q);
    end else begin
      walk_end = (pos_q > lsrs_pkg::MaxPosC);
    end
  end

  assign blk_edge = backward ? (pos_q[OfsW-1:0] == '0) : (pos_q[OfsW-1:0] == OfsW'(1));

  always_comb begin
    if (walk_q == lsrs_pkg::WK_COUNT) begin
      skip = blk_edge && ((pos_q + PosW'(BlkLen - 1)) <= lim_q);
    end else begin
      skip = blk_edge && (StepW'(row_cnt) < rem_q);
    end
  end

  assign hit = (walk_q != lsrs_pkg::WK_COUNT) && !skip && pos_live && (rem_q == StepW'(1));

  always_comb begin
    if (skip) begin
      pos_step = backward ? pos_q - PosW'(BlkLen) : pos_q + PosW'(BlkLen);
    end else begin
      pos_step = backward ? pos_q - PosW'(1) : pos_q + PosW'(1);
    end
  end

  assign step_new_blk = backward ? (pos_step[OfsW-1:0] == '0)
                                 : (pos_step[OfsW-1:0] == OfsW'(1));

  assign accept   = in_valid_i && in_ready_o;
  assign out_load = (state_q == lsrs_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  // Clamp the configured count to 1..MaxPos
  always_comb begin
    if (cfg_q == '0) begin
      eff_cnt = PosW'(1);
    end else if (cfg_q > lsrs_pkg::MaxPosC) begin
      eff_cnt = lsrs_pkg::MaxPosC;
    end else begin
      eff_cnt = cfg_q;
    end
  end

  // Build the clear row for the current sweep index
  logic [PosW-1:0]   clr_base, clr_diff;
  logic [CntW-1:0]   clr_n;
  logic [BlkLen-1:0] clr_live;

  assign clr_base = PosW'({clr_idx_q, {OfsW{1'b0}}});
  assign clr_diff = clr_cnt_q - clr_base;

  always_comb begin
    if (clr_cnt_q <= clr_base) begin
      clr_n = '0;
    end else if (clr_diff >= PosW'(BlkLen)) begin
      clr_n = CntW'(BlkLen);
    end else begin
      clr_n = clr_diff[CntW-1:0];
    end
    if (clr_n[CntW-1]) begin
      clr_live = '1;
    end else begin
      clr_live = (BlkLen'(1) << clr_n[OfsW-1:0]) - BlkLen'(1);
    end
  end

  // Walk finishes when it runs off its range or hits the wanted position
  logic walk_fin;
  assign walk_fin = walk_end || hit;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lsrs_pkg::ST_CLEAR: begin
        if (clr_idx_q == '1) begin
          state_d = clr_op_q ? lsrs_pkg::ST_DONE : lsrs_pkg::ST_IDLE;
        end
      end
      lsrs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (in_req_i.opcode)
            lsrs_pkg::OpClear: state_d = lsrs_pkg::ST_CLEAR;
            lsrs_pkg::OpDelete: begin
              if (in_req_i.position_a == '0 || in_req_i.position_a > lsrs_pkg::MaxPosC) begin
                state_d = lsrs_pkg::ST_DONE;
              end else begin
                state_d = lsrs_pkg::ST_DEL_RD;
              end
            end
            lsrs_pkg::OpNext, lsrs_pkg::OpPrev: begin
              state_d = (in_req_i.step == '0) ? lsrs_pkg::ST_DONE : lsrs_pkg::ST_WALK_RD;
            end
            lsrs_pkg::OpCount: begin
              if (in_req_i.position_a >= ((in_req_i.position_b > lsrs_pkg::MaxPosC)
                                          ? lsrs_pkg::MaxPosC : in_req_i.position_b)) begin
                state_d = lsrs_pkg::ST_DONE;
              end else begin
                state_d = lsrs_pkg::ST_WALK_RD;
              end
            end
            default: state_d = lsrs_pkg::ST_DONE;
          endcase
        end
      end
      lsrs_pkg::ST_DEL_RD: state_d = lsrs_pkg::ST_DEL_CHK;
      lsrs_pkg::ST_DEL_CHK: begin
        if (row_dead[a_m1[OfsW-1:0]]) begin
          state_d = lsrs_pkg::ST_DONE;
        end else if (last_q == a_q || first_q == a_q) begin
          state_d = lsrs_pkg::ST_WALK_RD;
        end else begin
          state_d = lsrs_pkg::ST_DONE;
        end
      end
      lsrs_pkg::ST_WALK_RD, lsrs_pkg::ST_WALK_SCAN: begin
        if (walk_fin || state_q == lsrs_pkg::ST_WALK_RD) begin
          // Row data is only valid in the scan state
          if ((state_q == lsrs_pkg::ST_WALK_SCAN) ? walk_fin : walk_end) begin
            if (walk_q == lsrs_pkg::WK_LAST && first_q == a_q) begin
              state_d = lsrs_pkg::ST_WALK_RD;
            end else begin
              state_d = lsrs_pkg::ST_DONE;
            end
          end else begin
            state_d = lsrs_pkg::ST_WALK_SCAN;
          end
        end else if (skip || step_new_blk) begin
          state_d = lsrs_pkg::ST_WALK_RD;
        end else begin
          state_d = lsrs_pkg::ST_WALK_SCAN;
        end
      end
      lsrs_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = lsrs_pkg::ST_IDLE;
        end
      end
      default: state_d = lsrs_pkg::ST_IDLE;
    endcase
  end

  // Datapath, RAM control and response
  always_comb begin
    walk_d      = walk_q;
    pos_d       = pos_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    lim_d       = lim_q;
    a_d         = a_q;
    clr_idx_d   = clr_idx_q;
    clr_cnt_d   = clr_cnt_q;
    clr_op_d    = clr_op_q;
    first_d     = first_q;
    last_d      = last_q;
    res_val_d   = res_val_q;
    res_err_d   = res_err_q;
    out_rsp_d   = out_rsp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cfg_d       = cfg_we_i ? cfg_wdata_i : cfg_q;
    ram_we      = 1'b0;
    ram_waddr   = clr_idx_q;
    ram_wdata   = {clr_n, ~clr_live};
    ram_re      = 1'b0;
    ram_raddr   = pos_m1[OfsW+BlkW-1:OfsW];

    case (state_q)
      lsrs_pkg::ST_CLEAR: begin
        // Write one row a cycle
        ram_we    = 1'b1;
        clr_idx_d = clr_idx_q + BlkW'(1);
      end
      lsrs_pkg::ST_IDLE: begin
        if (accept) begin
          a_d       = in_req_i.position_a;
          res_val_d = '0;
          res_err_d = 1'b0;
          rem_d     = in_req_i.step;
          acc_d     = '0;
          lim_d     = (in_req_i.position_b > lsrs_pkg::MaxPosC)
                      ? lsrs_pkg::MaxPosC : in_req_i.position_b;
          case (in_req_i.opcode)
            lsrs_pkg::OpClear: begin
              clr_cnt_d = eff_cnt;
              clr_idx_d = '0;
              clr_op_d  = 1'b1;
              first_d   = PosW'(1);
              last_d    = eff_cnt;
              res_val_d = eff_cnt;
            end
            lsrs_pkg::OpDelete: begin
              if (in_req_i.position_a == '0 || in_req_i.position_a > lsrs_pkg::MaxPosC) begin
                res_err_d = 1'b1;
              end
            end
            lsrs_pkg::OpNext: begin
              walk_d = lsrs_pkg::WK_NEXT;
              if (in_req_i.step == '0) begin
                res_val_d = in_req_i.position_a;
              end
              pos_d = (in_req_i.position_a >= lsrs_pkg::MaxPosC)
                      ? lsrs_pkg::MaxPosC + PosW'(1) : in_req_i.position_a + PosW'(1);
            end
            lsrs_pkg::OpPrev: begin
              walk_d = lsrs_pkg::WK_PREV;
              if (in_req_i.step == '0) begin
                res_val_d = in_req_i.position_a;
              end
              if (in_req_i.position_a > lsrs_pkg::MaxPosC) begin
                pos_d = lsrs_pkg::MaxPosC;
              end else if (in_req_i.position_a == '0) begin
                pos_d = '0;
              end else begin
                pos_d = in_req_i.position_a - PosW'(1);
              end
            end
            lsrs_pkg::OpCount: begin
              walk_d = lsrs_pkg::WK_COUNT;
              pos_d  = in_req_i.position_a + PosW'(1);
            end
            default: ;
          endcase
        end
      end
      lsrs_pkg::ST_DEL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = a_m1[OfsW+BlkW-1:OfsW];
      end
      lsrs_pkg::ST_DEL_CHK: begin
        if (row_dead[a_m1[OfsW-1:0]]) begin
          res_err_d = 1'b1;
        end else begin
          // Kill the position and drop the block count
          ram_we    = 1'b1;
          ram_waddr = a_m1[OfsW+BlkW-1:OfsW];
          ram_wdata = {(row_cnt != '0) ? row_cnt - CntW'(1) : row_cnt,
                       row_dead | (BlkLen'(1) << a_m1[OfsW-1:0])};
          res_val_d = a_q;
          rem_d     = StepW'(1);
          if (last_q == a_q) begin
            walk_d = lsrs_pkg::WK_LAST;
            pos_d  = a_m1;
          end else begin
            walk_d = lsrs_pkg::WK_FIRST;
            pos_d  = a_q + PosW'(1);
          end
        end
      end
      lsrs_pkg::ST_WALK_RD, lsrs_pkg::ST_WALK_SCAN: begin
        if (state_q == lsrs_pkg::ST_WALK_RD && !walk_end) begin
          ram_re = 1'b1;
        end else if (walk_fin) begin
          case (walk_q)
            lsrs_pkg::WK_NEXT, lsrs_pkg::WK_PREV: begin
              res_val_d = walk_end ? '0 : pos_q;
              res_err_d = walk_end;
            end
            lsrs_pkg::WK_COUNT: res_val_d = acc_q;
            lsrs_pkg::WK_LAST: begin
              last_d = walk_end ? '0 : pos_q;
              if (first_q == a_q) begin
                walk_d = lsrs_pkg::WK_FIRST;
                pos_d  = a_q + PosW'(1);
                rem_d  = StepW'(1);
              end
            end
            lsrs_pkg::WK_FIRST: first_d = walk_end ? '0 : pos_q;
            default: ;
          endcase
        end else begin
          // Advance by a block or by one position
          pos_d = pos_step;
          if (walk_q == lsrs_pkg::WK_COUNT) begin
            acc_d = skip ? acc_q + PosW'(row_cnt) : acc_q + PosW'(pos_live);
          end else begin
            rem_d = skip ? rem_q - StepW'(row_cnt) : rem_q - StepW'(pos_live);
          end
        end
      end
      lsrs_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_d          = 1'b1;
          out_rsp_d.value      = res_val_q;
          out_rsp_d.error      = res_err_q;
          out_rsp_d.first_live = first_q;
          out_rsp_d.last_live  = last_q;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsrs_pkg::ST_CLEAR;
      walk_q      <= lsrs_pkg::WK_NEXT;
      cfg_q       <= lsrs_pkg::MaxPosC;
      clr_idx_q   <= '0;
      clr_cnt_q   <= lsrs_pkg::MaxPosC;
      clr_op_q    <= 1'b0;
      first_q     <= PosW'(1);
      last_q      <= lsrs_pkg::MaxPosC;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      walk_q      <= walk_d;
      cfg_q       <= cfg_d;
      clr_idx_q   <= clr_idx_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_op_q    <= clr_op_d;
      first_q     <= first_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    rem_q     <= rem_d;
    acc_q     <= acc_d;
    lim_q     <= lim_d;
    a_q       <= a_d;
    res_val_q <= res_val_d;
    res_err_q <= res_err_d;
    out_rsp_q <= out_rsp_d;
  end

  assign in_ready_o  = (state_q == lsrs_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Checks on the sequencer
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("row RAM read and write to the same row");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.error) |-> (out_rsp_o.value == '0))
    else $error("flagged response carries a value");

  a_marks_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lsrs_pkg::ST_IDLE) |-> ((first_q == '0) == (last_q == '0)) && (first_q <= last_q))
    else $error("first and last live marks disagree");

  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lsrs_pkg::ST_WALK_SCAN && walk_q != lsrs_pkg::WK_COUNT) |-> (rem_q != '0))
    else $error("search running with nothing left to find");

endmodule

// ----- rtl/core/lsrs_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module lsrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, and register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- tb/live_slot_rank_select_top_tb.sv -----
// Testbench for the live slot rank/select block: directed and random requests against a predictor.
`timescale 1ns / 1ps

module live_slot_rank_select_top_tb;

  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned PosW     = lsrs_pkg::PosW;
  localparam int unsigned StepW    = lsrs_pkg::StepW;
  localparam int unsigned MaxPos   = lsrs_pkg::MaxPos;
  localparam int unsigned BlkLen   = lsrs_pkg::BlkLen;
  localparam int unsigned BlkCount = lsrs_pkg::BlkCount;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [PosW-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  lsrs_pkg::req_t in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  lsrs_pkg::rsp_t out_rsp_o;

  live_slot_rank_select_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // Predictor state
  logic [PosW-1:0] pos_count_q;
  bit              dead_q [1:MaxPos];
  int unsigned     blk_live_q [BlkCount];
  int unsigned     first_q, last_q;

  lsrs_pkg::rsp_t rsp_queue [$];
  int unsigned err_count;
  int unsigned req_count;
  int unsigned rsp_count;
  int unsigned idle_cycles;
  bit          drain;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned live_count_eff();
    int unsigned c;
    c = pos_count_q;
    if (c == 0) c = 1;
    if (c > MaxPos) c = MaxPos;
    return c;
  endfunction

  function automatic bit pos_live(int unsigned p);
    return p >= 1 && p <= MaxPos && !dead_q[p];
  endfunction

  function automatic void model_clear();
    int unsigned c;
    c = live_count_eff();
    for (int b = 0; b < BlkCount; b++) blk_live_q[b] = 0;
    for (int unsigned p = 1; p <= MaxPos; p++) begin
      dead_q[p] = p > c;
      if (p <= c) blk_live_q[(p - 1) / BlkLen]++;
    end
    first_q = 1;
    last_q  = c;
  endfunction

  // Walk forward, skipping whole blocks by their counts
  function automatic bit seek_next(int unsigned a, int unsigned rem, output int unsigned res);
    int unsigned p;
    res = 0;
    p = a + 1;
    while (p <= MaxPos) begin
      if ((p - 1) % BlkLen == 0 && blk_live_q[(p - 1) / BlkLen] < rem) begin
        rem -= blk_live_q[(p - 1) / BlkLen];
        p += BlkLen;
      end else begin
        if (pos_live(p)) begin
          rem--;
          if (rem == 0) begin
            res = p;
            return 1'b1;
          end
        end
        p++;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit seek_prev(int unsigned a, int unsigned rem, output int unsigned res);
    int p;
    res = 0;
    if (a == 0) return 1'b0;
    p = (a > MaxPos) ? MaxPos : a - 1;
    while (p >= 1) begin
      if (p % BlkLen == 0 && blk_live_q[(p - 1) / BlkLen] < rem) begin
        rem -= blk_live_q[(p - 1) / BlkLen];
        p -= BlkLen;
      end else begin
        if (pos_live(p)) begin
          rem--;
          if (rem == 0) begin
            res = p;
            return 1'b1;
          end
        end
        p--;
      end
    end
    return 1'b0;
  endfunction

  function automatic int unsigned live_between(int unsigned a, int unsigned b);
    int unsigned n;
    n = 0;
    if (b > MaxPos) b = MaxPos;
    for (int unsigned p = a + 1; p <= b; p++) if (pos_live(p)) n++;
    return n;
  endfunction

  function automatic lsrs_pkg::rsp_t predict_rank(lsrs_pkg::req_t r);
    lsrs_pkg::rsp_t o;
    int unsigned    v, found;
    bit             e;
    v = 0;
    e = 1'b0;
    case (r.opcode)
      lsrs_pkg::OpClear: begin
        model_clear();
        v = live_count_eff();
      end
      lsrs_pkg::OpDelete: begin
        if (!pos_live(r.position_a)) begin
          e = 1'b1;
        end else begin
          dead_q[r.position_a] = 1'b1;
          blk_live_q[(r.position_a - 1) / BlkLen]--;
          if (last_q == r.position_a) begin
            last_q = 0;
            for (int p = int'(r.position_a) - 1; p >= 1; p--)
              if (pos_live(p)) begin
                last_q = p;
                break;
              end
          end
          if (first_q == r.position_a) begin
            first_q = 0;
            for (int unsigned p = r.position_a + 1; p <= MaxPos; p++)
              if (pos_live(p)) begin
                first_q = p;
                break;
              end
          end
          v = r.position_a;
        end
      end
      lsrs_pkg::OpNext, lsrs_pkg::OpPrev: begin
        if (r.step == 0) v = r.position_a;
        else if (r.opcode == lsrs_pkg::OpNext ? seek_next(r.position_a, r.step, found)
                                              : seek_prev(r.position_a, r.step, found)) v = found;
        else e = 1'b1;
      end
      lsrs_pkg::OpCount: v = live_between(r.position_a, r.position_b);
      default: ;
    endcase
    o.value      = v[PosW-1:0];
    o.error      = e;
    o.first_live = first_q[PosW-1:0];
    o.last_live  = last_q[PosW-1:0];
    return o;
  endfunction

  // Send one request, with a random gap first
  task automatic send_req(logic [2:0] op, int unsigned a, int unsigned b, int unsigned st);
    lsrs_pkg::req_t r;
    int unsigned    gap;
    gap          = $urandom_range(0, 7);
    r.opcode     = op;
    r.position_a = a[PosW-1:0];
    r.position_b = b[PosW-1:0];
    r.step       = st[StepW-1:0];
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    rsp_queue.push_back(predict_rank(r));
    req_count++;
  endtask

  // Drop the request line after the last request of a sequence
  task automatic drop_req();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Wait for every response, then write the register
  task automatic set_count(int unsigned c);
    drop_req();
    wait (rsp_queue.size() == 0);
    repeat (300) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c[PosW-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    pos_count_q = c[PosW-1:0];
  endtask

  // Accept responses with random stalls and check them
  initial begin
    lsrs_pkg::rsp_t exp_rsp;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(0, 7) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        rsp_count++;
        if (rsp_queue.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("unexpected response %p", out_rsp_o);
        end else begin
          exp_rsp = rsp_queue.pop_front();
          if (out_rsp_o !== exp_rsp) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: expected value %0d err %0d first %0d last %0d, got %0d %0d %0d %0d",
                       exp_rsp.value, exp_rsp.error, exp_rsp.first_live, exp_rsp.last_live,
                       out_rsp_o.value, out_rsp_o.error, out_rsp_o.first_live,
                       out_rsp_o.last_live);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit && (rsp_queue.size() != 0 || in_valid_i)) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_directed();
    send_req(lsrs_pkg::OpCount, 0, 4096, 0);
    send_req(lsrs_pkg::OpNext, 0, 0, 4095);
    send_req(lsrs_pkg::OpNext, 1, 0, 4095);
    send_req(lsrs_pkg::OpPrev, 4096, 0, 4095);
    send_req(lsrs_pkg::OpPrev, 0, 0, 1);
    send_req(lsrs_pkg::OpNext, 77, 0, 0);
    send_req(lsrs_pkg::OpDelete, 1, 0, 0);
    send_req(lsrs_pkg::OpDelete, 1, 0, 0);
    send_req(lsrs_pkg::OpDelete, 4096, 0, 0);
    send_req(lsrs_pkg::OpDelete, 0, 0, 0);
    send_req(lsrs_pkg::OpDelete, 5000, 0, 0);
    send_req(lsrs_pkg::OpCount, 100, 50, 0);
    send_req(lsrs_pkg::OpCount, 63, 8191, 0);
    send_req(lsrs_pkg::OpPrev, 8191, 0, 3);
    send_req(lsrs_pkg::OpNext, 8191, 0, 1);
    send_req(3'd5, 1, 2, 3);
    send_req(3'd7, 8191, 8191, 4095);
  endtask

  task automatic test_small_counts();
    set_count(0);
    send_req(lsrs_pkg::OpClear, 0, 0, 0);
    send_req(lsrs_pkg::OpDelete, 1, 0, 0);
    send_req(lsrs_pkg::OpNext, 0, 0, 1);
    send_req(lsrs_pkg::OpPrev, 5, 0, 1);
    set_count(8191);
    send_req(lsrs_pkg::OpClear, 0, 0, 0);
    set_count(3);
    send_req(lsrs_pkg::OpClear, 0, 0, 0);
    send_req(lsrs_pkg::OpDelete, 2, 0, 0);
    send_req(lsrs_pkg::OpDelete, 3, 0, 0);
    send_req(lsrs_pkg::OpNext, 0, 0, 1);
  endtask

  // Random phases: after each clear, a mix of deletes, searches, counts and unknown opcodes
  task automatic test_random(int unsigned n);
    int unsigned k, c, op;
    for (int ph = 0; ph < 8; ph++) begin
      c = (ph == 0) ? 4096 : (ph == 1) ? 1 : $urandom_range(1, 4096);
      if (ph == 7) c = $urandom_range(4097, 8191);
      set_count(c);
      send_req(lsrs_pkg::OpClear, 0, 0, 0);
      c = live_count_eff();
      for (k = 0; k < n / 8; k++) begin
        op = $urandom_range(0, 99);
        if (op < 35)
          send_req(lsrs_pkg::OpDelete, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                                                   : $urandom_range(1, c), 0, 0);
        else if (op < 60)
          send_req(lsrs_pkg::OpNext, $urandom_range(0, 8191) % (c + 2),
                   $urandom, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                         : $urandom_range(0, 70));
        else if (op < 85)
          send_req(lsrs_pkg::OpPrev, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                                                 : $urandom_range(0, c + 1),
                   $urandom, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                         : $urandom_range(0, 70));
        else if (op < 97)
          send_req(lsrs_pkg::OpCount, $urandom_range(0, 8191) % (c + 2),
                   $urandom_range(0, 8191), $urandom);
        else
          send_req(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    err_count   = 0;
    req_count   = 0;
    rsp_count   = 0;
    idle_cycles = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    pos_count_q = 13'd4096;
    model_clear();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_small_counts();
    test_random(1120);

    drop_req();
    wait (rsp_queue.size() == 0);
    repeat (300) @(negedge clk_i);
    $display("Covered %0d requests and %0d responses over clear, delete, next, previous,",
             req_count, rsp_count);
    $display("count and unknown opcodes at several position counts.");
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/lsrs_pkg.sv
rtl/core/lsrs_ram.sv
rtl/core/live_slot_rank_select_top.sv
tb/live_slot_rank_select_top_tb.sv
